### src/tpss_pkg.sv
// Shared widths, codes, types and reset values of the timed pose sequencer.
package tpss_pkg;

    localparam int ANGLE_W   = 20;
    localparam int STEP_W    = 16;
    localparam int DWELL_W   = 16;
    localparam int ACT_W     = 2;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic [STEP_W-1:0]         t_step;
    typedef logic [DWELL_W-1:0]        t_dwell;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LARGE_OPEN   = 3'd0,
        CFG_LARGE_CLOSED = 3'd1,
        CFG_SMALL_OPEN   = 3'd2,
        CFG_SMALL_CLOSED = 3'd3,
        CFG_LARGE_STEP   = 3'd4,
        CFG_SMALL_STEP   = 3'd5,
        CFG_DWELL        = 3'd6
    } t_cfg_idx;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE   = 2'd0,
        ACT_ENTER  = 2'd1,
        ACT_EXIT   = 2'd2,
        ACT_SETPOS = 2'd3
    } t_action;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE        = 2'd0,
        PH_FIRST_CLOSE = 2'd1,
        PH_OPEN        = 2'd2,
        PH_FINAL_CLOSE = 2'd3
    } t_phase_code;

    typedef enum logic [3:0] {
        SEQ_IDLE        = 4'b0001,
        SEQ_FIRST_CLOSE = 4'b0010,
        SEQ_OPEN        = 4'b0100,
        SEQ_FINAL_CLOSE = 4'b1000
    } t_seq_state;

    typedef struct packed {
        t_angle large_open;
        t_angle large_closed;
        t_angle small_open;
        t_angle small_closed;
        t_step  large_step;
        t_step  small_step;
        t_dwell phase_len;
    } t_cfg;

    typedef struct packed {
        logic   mode;
        logic   enabled;
        t_angle large_measured;
        t_angle small_measured;
        logic   large_running;
        logic   small_running;
        logic   large_stopped;
        logic   small_stopped;
    } t_in_word;

    localparam t_step  STEP_RESET  = 16'd8;
    localparam t_dwell DWELL_RESET = 16'd500;

endpackage

### src/tpss_if.sv
// Valid/ready channel interfaces for input words and result words.
interface tpss_in_if;
    import tpss_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    logic   enabled;
    t_angle large_measured;
    t_angle small_measured;
    logic   large_running;
    logic   small_running;
    logic   large_stopped;
    logic   small_stopped;

    modport source (
        output valid, mode, enabled, large_measured, small_measured,
               large_running, small_running, large_stopped, small_stopped,
        input  ready
    );
    modport sink (
        input  valid, mode, enabled, large_measured, small_measured,
               large_running, small_running, large_stopped, small_stopped,
        output ready
    );
endinterface

interface tpss_out_if;
    import tpss_pkg::*;

    logic               valid;
    logic               ready;
    t_angle             large_setpoint;
    t_angle             small_setpoint;
    logic [ACT_W-1:0]   large_action;
    logic [ACT_W-1:0]   small_action;
    logic [PHASE_W-1:0] phase;
    logic               trigger_taken;

    modport source (
        output valid, large_setpoint, small_setpoint, large_action, small_action,
               phase, trigger_taken,
        input  ready
    );
    modport sink (
        input  valid, large_setpoint, small_setpoint, large_action, small_action,
               phase, trigger_taken,
        output ready
    );
endinterface

### src/tpss_cfg.sv
// Configuration register bank written through the plain write port.
module tpss_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tpss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tpss_pkg::ANGLE_W-1:0]      i_cfg_wdata,
    output tpss_pkg::t_cfg                    o_cfg
);
    import tpss_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LARGE_OPEN:   n_cfg.large_open   = t_angle'(i_cfg_wdata);
                CFG_LARGE_CLOSED: n_cfg.large_closed = t_angle'(i_cfg_wdata);
                CFG_SMALL_OPEN:   n_cfg.small_open   = t_angle'(i_cfg_wdata);
                CFG_SMALL_CLOSED: n_cfg.small_closed = t_angle'(i_cfg_wdata);
                CFG_LARGE_STEP:   n_cfg.large_step   = i_cfg_wdata[STEP_W-1:0];
                CFG_SMALL_STEP:   n_cfg.small_step   = i_cfg_wdata[STEP_W-1:0];
                CFG_DWELL:        n_cfg.phase_len    = i_cfg_wdata[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.large_open   <= '0;
            r_cfg.large_closed <= '0;
            r_cfg.small_open   <= '0;
            r_cfg.small_closed <= '0;
            r_cfg.large_step   <= STEP_RESET;
            r_cfg.small_step   <= STEP_RESET;
            r_cfg.phase_len    <= DWELL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/tpss_slew.sv
// Slew limiter: moves one angle toward its target by at most one step.
module tpss_slew (
    input  tpss_pkg::t_angle i_cur,
    input  tpss_pkg::t_angle i_target,
    input  tpss_pkg::t_step  i_step,
    output tpss_pkg::t_angle o_next
);
    import tpss_pkg::*;

    logic signed [ANGLE_W:0] diff;
    logic signed [ANGLE_W:0] step_s;
    t_angle                  step_a;

    assign diff   = $signed({i_target[ANGLE_W-1], i_target})
                  - $signed({i_cur[ANGLE_W-1], i_cur});
    assign step_s = $signed({{(ANGLE_W+1-STEP_W){1'b0}}, i_step});
    assign step_a = t_angle'({{(ANGLE_W-STEP_W){1'b0}}, i_step});

    // The result always lies between the current value and the target, so
    // the 20-bit wrap of the add and subtract never shows.
    always_comb begin
        if (diff > step_s) begin
            o_next = i_cur + step_a;
        end else if (diff < -step_s) begin
            o_next = i_cur - step_a;
        end else begin
            o_next = i_target;
        end
    end

endmodule

### src/tpss_core.sv
// Input register, sequencer and smoothing state, and result register.
module tpss_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpss_pkg::t_cfg i_cfg,
    tpss_in_if.sink        i_in_ch,
    tpss_out_if.source     o_out_ch
);
    import tpss_pkg::*;

    t_in_word   r_in;
    logic       r_in_valid;
    logic       r_out_valid;

    t_angle     r_large_sm, n_large_sm;
    t_angle     r_small_sm, n_small_sm;
    t_seq_state r_seq, n_seq;
    t_dwell     r_ticks, n_ticks;
    logic       r_large_closed, n_large_closed;
    logic       r_small_closed, n_small_closed;
    t_action    r_large_act, n_large_act;
    t_action    r_small_act, n_small_act;
    logic       r_taken, n_taken;

    t_seq_state adv_seq;
    t_dwell     adv_ticks;
    logic       adv_large_closed;
    logic       adv_small_closed;
    t_dwell     limit;
    logic [DWELL_W:0] ticks_inc;
    t_angle     large_target, small_target;
    t_angle     large_slewed, small_slewed;
    t_phase_code phase_code;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign advance  = r_in_valid && out_free;
    assign in_take  = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = !r_in_valid || out_free;

    // Sequence step of an enabled tick; a dwell of zero behaves as one.
    assign limit     = (i_cfg.phase_len == '0) ? t_dwell'(1) : i_cfg.phase_len;
    assign ticks_inc = {1'b0, r_ticks} + {{DWELL_W{1'b0}}, 1'b1};

    always_comb begin
        adv_seq          = r_seq;
        adv_ticks        = r_ticks;
        adv_large_closed = r_large_closed;
        adv_small_closed = r_small_closed;
        if (r_seq != SEQ_IDLE) begin
            if (ticks_inc < {1'b0, limit}) begin
                adv_ticks = ticks_inc[DWELL_W-1:0];
            end else begin
                adv_ticks = '0;
                case (r_seq)
                    SEQ_FIRST_CLOSE: begin
                        adv_seq          = SEQ_OPEN;
                        adv_large_closed = 1'b0;
                        adv_small_closed = 1'b0;
                    end
                    SEQ_OPEN: begin
                        adv_seq          = SEQ_FINAL_CLOSE;
                        adv_large_closed = 1'b1;
                        adv_small_closed = 1'b1;
                    end
                    default: adv_seq = SEQ_IDLE;
                endcase
            end
        end
    end

    assign large_target = adv_large_closed ? i_cfg.large_closed : i_cfg.large_open;
    assign small_target = adv_small_closed ? i_cfg.small_closed : i_cfg.small_open;

    tpss_slew u_large_slew (
        .i_cur    (r_large_sm),
        .i_target (large_target),
        .i_step   (i_cfg.large_step),
        .o_next   (large_slewed)
    );

    tpss_slew u_small_slew (
        .i_cur    (r_small_sm),
        .i_target (small_target),
        .i_step   (i_cfg.small_step),
        .o_next   (small_slewed)
    );

    always_comb begin
        n_large_sm     = r_large_sm;
        n_small_sm     = r_small_sm;
        n_seq          = r_seq;
        n_ticks        = r_ticks;
        n_large_closed = r_large_closed;
        n_small_closed = r_small_closed;
        n_large_act    = ACT_NONE;
        n_small_act    = ACT_NONE;
        n_taken        = 1'b0;
        if (r_in.mode) begin
            if (r_in.enabled && (r_seq == SEQ_IDLE)) begin
                n_seq          = SEQ_FIRST_CLOSE;
                n_ticks        = '0;
                n_large_closed = 1'b1;
                n_small_closed = 1'b1;
                n_taken        = 1'b1;
            end
        end else if (!r_in.enabled) begin
            // Disabled: follow the measured angles and abort the sequence.
            n_large_act = r_in.large_stopped ? ACT_NONE : ACT_EXIT;
            n_small_act = r_in.small_stopped ? ACT_NONE : ACT_EXIT;
            n_large_sm  = r_in.large_measured;
            n_small_sm  = r_in.small_measured;
            n_seq       = SEQ_IDLE;
            n_ticks     = '0;
        end else begin
            n_seq          = adv_seq;
            n_ticks        = adv_ticks;
            n_large_closed = adv_large_closed;
            n_small_closed = adv_small_closed;
            n_large_sm     = large_slewed;
            n_small_sm     = small_slewed;
            n_large_act    = r_in.large_running ? ACT_SETPOS : ACT_ENTER;
            n_small_act    = r_in.small_running ? ACT_SETPOS : ACT_ENTER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.mode           <= i_in_ch.mode;
            r_in.enabled        <= i_in_ch.enabled;
            r_in.large_measured <= i_in_ch.large_measured;
            r_in.small_measured <= i_in_ch.small_measured;
            r_in.large_running  <= i_in_ch.large_running;
            r_in.small_running  <= i_in_ch.small_running;
            r_in.large_stopped  <= i_in_ch.large_stopped;
            r_in.small_stopped  <= i_in_ch.small_stopped;
        end
        if (advance) begin
            r_large_act <= n_large_act;
            r_small_act <= n_small_act;
            r_taken     <= n_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_large_sm     <= '0;
            r_small_sm     <= '0;
            r_seq          <= SEQ_IDLE;
            r_ticks        <= '0;
            r_large_closed <= 1'b0;
            r_small_closed <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid    <= 1'b1;
                r_large_sm     <= n_large_sm;
                r_small_sm     <= n_small_sm;
                r_seq          <= n_seq;
                r_ticks        <= n_ticks;
                r_large_closed <= n_large_closed;
                r_small_closed <= n_small_closed;
            end else if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The smoothing state only moves when the result register is free, so the
    // state registers double as the setpoint and phase outputs.
    always_comb begin
        case (r_seq)
            SEQ_IDLE:        phase_code = PH_IDLE;
            SEQ_FIRST_CLOSE: phase_code = PH_FIRST_CLOSE;
            SEQ_OPEN:        phase_code = PH_OPEN;
            SEQ_FINAL_CLOSE: phase_code = PH_FINAL_CLOSE;
            default:         phase_code = PH_IDLE;
        endcase
    end

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.large_setpoint = r_large_sm;
    assign o_out_ch.small_setpoint = r_small_sm;
    assign o_out_ch.large_action   = r_large_act;
    assign o_out_ch.small_action   = r_small_act;
    assign o_out_ch.phase          = phase_code;
    assign o_out_ch.trigger_taken  = r_taken;

endmodule

### src/timed_pose_sequencer_with_slew_limit.sv
// An accepted word goes into the input register; its result then goes into the
// state and result registers, which are shown as the result word.
// Throughput: one word per cycle while results are taken; sequencing and slewing
// are combinational; the input and result registers decouple the two channels.
// Reset (synchronous, active low): both channels empty, setpoints zero, sequence
// idle with the open pose, angle registers zero, steps 8 and dwell 500 ticks.
module timed_pose_sequencer_with_slew_limit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tpss_pkg::ANGLE_W-1:0]   i_cfg_wdata,
    tpss_in_if.sink                        i_in_ch,
    tpss_out_if.source                     o_out_ch
);
    import tpss_pkg::*;

    t_cfg cfg;

    tpss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    tpss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch)
    );

endmodule

### verif/timed_pose_sequencer_with_slew_limit_test.sv
// Self-checking testbench for the timed pose sequencer with slew limit.
module timed_pose_sequencer_with_slew_limit_test;
    import tpss_pkg::*;

    localparam t_angle ANGLE_MAX = t_angle'(20'h7FFFF);
    localparam t_angle ANGLE_MIN = t_angle'(20'h80000);
    localparam logic   WORD_TICK = 1'b0;
    localparam logic   WORD_TRIG = 1'b1;

    typedef struct packed {
        t_angle      large_sp;
        t_angle      small_sp;
        t_action     large_act;
        t_action     small_act;
        t_phase_code ph;
        logic        taken;
    } t_pose_result;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     cfg_we = 1'b0;
    t_cfg_idx cfg_idx = CFG_LARGE_OPEN;
    logic [ANGLE_W-1:0] cfg_wdata = '0;

    tpss_in_if  in_ch ();
    tpss_out_if out_ch ();

    timed_pose_sequencer_with_slew_limit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_ch     (in_ch),
        .o_out_ch    (out_ch)
    );

    // Predicted register contents and sequencer state.
    t_angle      cfg_large_open   = '0;
    t_angle      cfg_large_closed = '0;
    t_angle      cfg_small_open   = '0;
    t_angle      cfg_small_closed = '0;
    t_step       cfg_large_step   = STEP_RESET;
    t_step       cfg_small_step   = STEP_RESET;
    t_dwell      cfg_dwell        = DWELL_RESET;
    t_angle      pred_large_sp    = '0;
    t_angle      pred_small_sp    = '0;
    t_phase_code pred_phase       = PH_IDLE;
    t_dwell      pred_ticks       = '0;
    bit          large_closed_pose = 1'b0;
    bit          small_closed_pose = 1'b0;

    t_in_word     pose_pending[$];
    t_pose_result pose_expected[$];
    int           mismatches = 0;

    int burst_left = 0;
    int gap_left   = 0;
    int stall_count = 0;
    int stall_mode  = 0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.mode           = 1'b0;
        in_ch.enabled        = 1'b0;
        in_ch.large_measured = '0;
        in_ch.small_measured = '0;
        in_ch.large_running  = 1'b0;
        in_ch.small_running  = 1'b0;
        in_ch.large_stopped  = 1'b0;
        in_ch.small_stopped  = 1'b0;
        out_ch.ready         = 1'b0;
    end

    function automatic t_angle slew_toward(t_angle cur, t_angle target, t_step step);
        longint c;
        longint t;
        longint s;
        c = cur;
        t = target;
        s = step;
        if (c < t - s) begin
            c = c + s;
        end else if (c > t + s) begin
            c = c - s;
        end else begin
            c = t;
        end
        return t_angle'(c);
    endfunction

    // A zero dwell behaves as a single tick per phase.
    function automatic void advance_phase();
        int unsigned limit;
        int unsigned count_up;
        limit = (cfg_dwell == 0) ? 1 : cfg_dwell;
        if (pred_phase == PH_IDLE) return;
        count_up = pred_ticks + 1;
        if (count_up < limit) begin
            pred_ticks = count_up[15:0];
            return;
        end
        pred_ticks = '0;
        case (pred_phase)
            PH_FIRST_CLOSE: begin
                pred_phase = PH_OPEN;
                large_closed_pose = 1'b0;
                small_closed_pose = 1'b0;
            end
            PH_OPEN: begin
                pred_phase = PH_FINAL_CLOSE;
                large_closed_pose = 1'b1;
                small_closed_pose = 1'b1;
            end
            default: pred_phase = PH_IDLE;
        endcase
    endfunction

    function automatic void predict_pose_word(t_in_word w);
        t_pose_result r;
        r.large_act = ACT_NONE;
        r.small_act = ACT_NONE;
        r.taken     = 1'b0;
        if (w.mode == WORD_TRIG) begin
            if (w.enabled && pred_phase == PH_IDLE) begin
                pred_phase = PH_FIRST_CLOSE;
                pred_ticks = '0;
                large_closed_pose = 1'b1;
                small_closed_pose = 1'b1;
                r.taken = 1'b1;
            end
        end else if (!w.enabled) begin
            r.large_act   = w.large_stopped ? ACT_NONE : ACT_EXIT;
            r.small_act   = w.small_stopped ? ACT_NONE : ACT_EXIT;
            pred_large_sp = w.large_measured;
            pred_small_sp = w.small_measured;
            pred_phase    = PH_IDLE;
            pred_ticks    = '0;
        end else begin
            advance_phase();
            pred_large_sp = slew_toward(pred_large_sp,
                large_closed_pose ? cfg_large_closed : cfg_large_open, cfg_large_step);
            pred_small_sp = slew_toward(pred_small_sp,
                small_closed_pose ? cfg_small_closed : cfg_small_open, cfg_small_step);
            r.large_act = w.large_running ? ACT_SETPOS : ACT_ENTER;
            r.small_act = w.small_running ? ACT_SETPOS : ACT_ENTER;
        end
        r.large_sp = pred_large_sp;
        r.small_sp = pred_small_sp;
        r.ph       = pred_phase;
        pose_expected.push_back(r);
    endfunction

    // Sender: bursts of words separated by random gaps.
    always @(posedge clk) begin : driver
        t_in_word w;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                w.mode           = in_ch.mode;
                w.enabled        = in_ch.enabled;
                w.large_measured = in_ch.large_measured;
                w.small_measured = in_ch.small_measured;
                w.large_running  = in_ch.large_running;
                w.small_running  = in_ch.small_running;
                w.large_stopped  = in_ch.large_stopped;
                w.small_stopped  = in_ch.small_stopped;
                predict_pose_word(w);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (pose_pending.size() != 0) begin
                    w = pose_pending.pop_front();
                    in_ch.mode           <= w.mode;
                    in_ch.enabled        <= w.enabled;
                    in_ch.large_measured <= w.large_measured;
                    in_ch.small_measured <= w.small_measured;
                    in_ch.large_running  <= w.large_running;
                    in_ch.small_running  <= w.small_running;
                    in_ch.large_stopped  <= w.large_stopped;
                    in_ch.small_stopped  <= w.small_stopped;
                    in_ch.valid          <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [ANGLE_W-1:0] want,
                               input logic [ANGLE_W-1:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: checks each result word and stalls on a changing pattern.
    always @(posedge clk) begin : monitor
        t_pose_result want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pose_expected.size() == 0) begin
                    $display("%0t unexpected result word: expected none, actual %h %h",
                             $time, out_ch.large_setpoint, out_ch.small_setpoint);
                    mismatches++;
                end else begin
                    want = pose_expected.pop_front();
                    check_field("large_setpoint", want.large_sp, out_ch.large_setpoint);
                    check_field("small_setpoint", want.small_sp, out_ch.small_setpoint);
                    check_field("large_action", ANGLE_W'(want.large_act),
                                ANGLE_W'(out_ch.large_action));
                    check_field("small_action", ANGLE_W'(want.small_act),
                                ANGLE_W'(out_ch.small_action));
                    check_field("phase", ANGLE_W'(want.ph), ANGLE_W'(out_ch.phase));
                    check_field("trigger_taken", ANGLE_W'(want.taken),
                                ANGLE_W'(out_ch.trigger_taken));
                end
            end
            stall_count++;
            if (stall_count % 200 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= (stall_count % 3) != 0;
                2:       out_ch.ready <= $urandom_range(0, 99) >= 40;
                default: out_ch.ready <= (stall_count % 16) >= 6;
            endcase
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [ANGLE_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LARGE_OPEN:   cfg_large_open   = val;
            CFG_LARGE_CLOSED: cfg_large_closed = val;
            CFG_SMALL_OPEN:   cfg_small_open   = val;
            CFG_SMALL_CLOSED: cfg_small_closed = val;
            CFG_LARGE_STEP:   cfg_large_step   = val[STEP_W-1:0];
            CFG_SMALL_STEP:   cfg_small_step   = val[STEP_W-1:0];
            CFG_DWELL:        cfg_dwell        = val[DWELL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(input t_angle lo, input t_angle lc, input t_angle so,
                                 input t_angle sc, input t_step ls, input t_step ss,
                                 input t_dwell dw);
        write_reg(CFG_LARGE_OPEN, lo);
        write_reg(CFG_LARGE_CLOSED, lc);
        write_reg(CFG_SMALL_OPEN, so);
        write_reg(CFG_SMALL_CLOSED, sc);
        write_reg(CFG_LARGE_STEP, ANGLE_W'(ls));
        write_reg(CFG_SMALL_STEP, ANGLE_W'(ss));
        write_reg(CFG_DWELL, ANGLE_W'(dw));
    endtask

    // Wait until every queued word is sent and every result word has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (pose_pending.size() != 0 || in_ch.valid || pose_expected.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic queue_fixed(input logic mode, input logic en, input t_angle lm,
                               input t_angle sm, input logic lr, input logic sr,
                               input logic ls, input logic ss);
        t_in_word w;
        w = {mode, en, lm, sm, lr, sr, ls, ss};
        pose_pending.push_back(w);
    endtask

    function automatic t_in_word random_word(int trig_pct, int dis_pct);
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        w.mode    = ($urandom_range(0, 99) < trig_pct) ? WORD_TRIG : WORD_TICK;
        w.enabled = $urandom_range(0, 99) >= dis_pct;
        if ($urandom_range(0, 9) == 0) w.large_measured = $urandom_range(0, 1) ? ANGLE_MAX
                                                                                 : ANGLE_MIN;
        if ($urandom_range(0, 9) == 0) w.small_measured = $urandom_range(0, 1) ? ANGLE_MAX
                                                                                 : ANGLE_MIN;
        return w;
    endfunction

    function automatic t_angle random_angle();
        case ($urandom_range(0, 5))
            0:       return ANGLE_MIN;
            1:       return ANGLE_MAX;
            2:       return '0;
            default: return t_angle'($urandom);
        endcase
    endfunction

    function automatic t_step random_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return t_step'($urandom_range(1, 64));
            3:       return t_step'($urandom_range(1, 4096));
            default: return t_step'($urandom);
        endcase
    endfunction

    function automatic t_dwell random_dwell();
        case ($urandom_range(0, 3))
            0:       return t_dwell'($urandom_range(0, 1));
            1:       return t_dwell'($urandom_range(2, 8));
            2:       return t_dwell'($urandom_range(9, 20));
            default: return t_dwell'($urandom_range(1, 40));
        endcase
    endfunction

    // A trigger followed by enabled ticks, enough to run the sequence out unless
    // capped at 60, with the odd stray word mixed in.
    task automatic queue_sequence(output int count);
        t_in_word w;
        int       limit;
        int       ticks;
        limit = (cfg_dwell == 0) ? 1 : cfg_dwell;
        ticks = 3 * limit + $urandom_range(0, 3);
        if (ticks > 60) ticks = 60;
        w = random_word(0, 0);
        w.mode = WORD_TRIG;
        pose_pending.push_back(w);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 99) < 3) w = random_word(40, 40);
            else w = random_word(0, 0);
            pose_pending.push_back(w);
        end
        count = ticks + 1;
    endtask

    initial begin : stimulus
        int issued;
        int chunk;
        t_dwell dw;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: actions, extreme measured angles and trigger handling.
        queue_fixed(WORD_TICK, 1'b1, ANGLE_MAX, ANGLE_MIN, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b0, 1'b0, 1'b1, 1'b1);
        queue_fixed(WORD_TICK, 1'b0, ANGLE_MAX, ANGLE_MIN, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_fixed(WORD_TICK, 1'b0, ANGLE_MIN, ANGLE_MAX, 1'b0, 1'b0, 1'b1, 1'b1);
        queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b1, 1'b0, 1'b0, 1'b1);
        queue_fixed(WORD_TRIG, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_fixed(WORD_TRIG, 1'b1, '0, '0, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_fixed(WORD_TRIG, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_fixed(WORD_TICK, 1'b0, t_angle'(20'h12345), t_angle'(20'hEDCBA),
                    1'b0, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // Extreme poses, full and zero step, zero dwell: one phase per tick,
        // and the closed pose stays after the sequence ends.
        apply_setting(ANGLE_MAX, ANGLE_MIN, ANGLE_MIN, ANGLE_MAX, '1, '0, '0);
        queue_fixed(WORD_TRIG, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        repeat (4) queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0);
        queue_fixed(WORD_TICK, 1'b0, '0, ANGLE_MAX, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // Lowering the dwell mid-phase ends the phase on the next tick.
        write_reg(CFG_DWELL, ANGLE_W'(10));
        write_reg(CFG_SMALL_STEP, ANGLE_W'(1));
        queue_fixed(WORD_TRIG, 1'b1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        repeat (6) queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0);
        wait_drained();
        write_reg(CFG_DWELL, ANGLE_W'(3));
        repeat (2) queue_fixed(WORD_TICK, 1'b1, '0, '0, 1'b1, 1'b1, 1'b0, 1'b0);

        for (int setting = 0; setting < 8; setting++) begin
            wait_drained();
            dw = (setting == 3) ? t_dwell'('1) : random_dwell();
            apply_setting(random_angle(), random_angle(), random_angle(), random_angle(),
                          random_step(), random_step(), dw);
            issued = 0;
            while (issued < 205) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_sequence(chunk);
                end else begin
                    chunk = $urandom_range(1, 6);
                    for (int i = 0; i < chunk; i++)
                        pose_pending.push_back(random_word(40, 30));
                end
                issued += chunk;
            end
        end

        wait_drained();
        repeat (8) @(negedge clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
